// ===== rtl/led_frame_grb_byte_packer_core_defines.svh =====
// Assertion macros used by the checker module.
`ifndef LED_FRAME_GRB_BYTE_PACKER_CORE_DEFINES_SVH
`define LED_FRAME_GRB_BYTE_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lgbp: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LGBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lgbp: assertion failed");

// Next-cycle implication that also holds across reset.
`define LGBP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("lgbp: reset assertion failed");

`endif

// ===== rtl/lgbp_pkg.sv =====
package lgbp_pkg;

    localparam int BRIGHT_W = 8;
    localparam int DIM_W    = 12;
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = 2 * CHAN_W;
    localparam int BYTE_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [BYTE_W-1:0]    HDR_START    = 8'h53;
    localparam logic [BYTE_W-1:0]    HDR_TAG      = 8'h54;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET = 8'hFF;
    localparam logic [CHAN_W:0]      FULL_SCALE   = 9'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_FORMAT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic FMT_SHORT = 1'b0;
    localparam logic FMT_LONG  = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HDR_SHORT,
        KIND_HDR_LONG
    } kind_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic                frame_format;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [PROD_W-1:0] prod_green;
        logic [PROD_W-1:0] prod_red;
        logic [PROD_W-1:0] prod_blue;
    } entry_t;

endpackage

// ===== rtl/lgbp_front.sv =====
module lgbp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lgbp_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lgbp_pkg::PIXEL_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    output lgbp_pkg::entry_t                    push_entry,
    output logic                                push_valid,
    input  logic                                push_ready
);
    import lgbp_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   keep;
    logic   accept;

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb begin
        entry_next.prod_red   = PROD_W'({8'd0, s_tdata[CHAN_W-1:0]})
                                * PROD_W'({8'd0, cfg.brightness});
        entry_next.prod_green = PROD_W'({8'd0, s_tdata[2*CHAN_W-1:CHAN_W]})
                                * PROD_W'({8'd0, cfg.brightness});
        entry_next.prod_blue  = PROD_W'({8'd0, s_tdata[3*CHAN_W-1:2*CHAN_W]})
                                * PROD_W'({8'd0, cfg.brightness});
        keep = 1'b1;
        if (s_tuser == CMD_PIXEL) begin
            entry_next.kind = KIND_PIXEL;
        end else if (cfg.frame_format == FMT_SHORT) begin
            entry_next.kind = KIND_HDR_SHORT;
        end else begin
            entry_next.kind = KIND_HDR_LONG;
            // oversized frame: header dropped
            keep = (cfg.frame_width[DIM_W-1:BYTE_W] == '0) &&
                   (cfg.frame_height[DIM_W-1:BYTE_W] == '0);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = keep;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/lgbp_queue.sv =====
module lgbp_queue #(
    parameter int DEPTH = lgbp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lgbp_pkg::entry_t push_entry,
    input  logic             push_valid,
    output logic             push_ready,
    output lgbp_pkg::entry_t head_entry,
    output logic             head_valid,
    input  logic             pop
);
    import lgbp_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    entry_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != COUNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/lgbp_back.sv =====
module lgbp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lgbp_pkg::cfg_t                 cfg,
    input  lgbp_pkg::entry_t               head_entry,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lgbp_pkg::BYTE_W-1:0]    m_tdata,
    output logic                           m_tlast
);
    import lgbp_pkg::*;

    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              load;
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] quot_lo;
    logic [CHAN_W:0]   rem;
    logic [CHAN_W-1:0] scaled;
    logic [BYTE_W-1:0] byte_sel;
    logic              last_sel;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign pop      = load && last_sel;

    // p / 255 for p <= 65025: p = 256*q + lo, remainder lo + q stays below 510
    always_comb begin
        case (idx_reg)
            2'd0:    prod = head_entry.prod_green;
            2'd1:    prod = head_entry.prod_red;
            default: prod = head_entry.prod_blue;
        endcase
        quot_lo = prod[PROD_W-1:CHAN_W];
        rem     = {1'b0, prod[CHAN_W-1:0]} + {1'b0, quot_lo};
        scaled  = quot_lo + CHAN_W'(rem >= FULL_SCALE);
    end

    always_comb begin
        unique case (head_entry.kind)
            KIND_PIXEL: begin
                byte_sel = scaled;
                last_sel = (idx_reg == 2'd2);
            end
            KIND_HDR_SHORT: begin
                byte_sel = HDR_START;
                last_sel = 1'b1;
            end
            KIND_HDR_LONG: begin
                case (idx_reg)
                    2'd0:    byte_sel = HDR_START;
                    2'd1:    byte_sel = HDR_TAG;
                    2'd2:    byte_sel = cfg.frame_width[BYTE_W-1:0];
                    default: byte_sel = cfg.frame_height[BYTE_W-1:0];
                endcase
                last_sel = (idx_reg == 2'd3);
            end
            default: begin
                byte_sel = HDR_START;
                last_sel = 1'b1;
            end
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = last_sel ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= byte_sel;
            out_last_reg <= last_sel;
        end
    end

endmodule

// ===== rtl/led_frame_grb_byte_packer_core.sv =====
// LED panel byte packer. Takes frame-start and RGB pixel transactions and
// sends the panel byte stream one byte per cycle while m_tready is high and
// bytes are queued: a pixel becomes the scaled green, red and blue bytes
// (channel * brightness / 255, rounded down), a frame start becomes 'S' or,
// in the long format, 'S','T',width,height, or nothing when width or height
// is above 255. tlast marks the final byte of each input transaction. A
// pixel yields three bytes, a header one or four, a dropped header none.
// The first byte passes the entry register, the queue and the output
// byte register. Write the registers only while the block is idle.
module led_frame_grb_byte_packer_core #(
    parameter int QUEUE_DEPTH = lgbp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lgbp_pkg::PIXEL_W-1:0]          s_tdata,  // red, green, blue
    input  logic                                  s_tuser,  // cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lgbp_pkg::BYTE_W-1:0]           m_tdata,  // out_byte
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lgbp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lgbp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lgbp_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    entry_t push_entry, head_entry;
    logic   push_valid, push_ready;
    logic   head_valid, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BRIGHTNESS:   cfg_next.brightness   = cfg_data[BRIGHT_W-1:0];
                REG_FRAME_FORMAT: cfg_next.frame_format = cfg_data[0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brightness   <= BRIGHT_RESET;
            cfg_reg.frame_format <= FMT_SHORT;
            cfg_reg.frame_width  <= '0;
            cfg_reg.frame_height <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lgbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    lgbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .pop        (pop)
    );

    lgbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/lgbp_checker.sv =====
`include "led_frame_grb_byte_packer_core_defines.svh"

module lgbp_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [lgbp_pkg::BYTE_W-1:0]           m_tdata,
    input logic                                  m_tlast,
    input logic                                  cfg_ready
);
    import lgbp_pkg::*;

    `LGBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `LGBP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    `LGBP_ASSERT_RST(a_reset_clears, !aresetn, !m_tvalid && s_tready && cfg_ready)

endmodule

bind led_frame_grb_byte_packer_core lgbp_checker u_lgbp_checker (.*);
